### sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Types and fixed widths for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_W = 32;
  localparam int NORM_W  = 16;
  localparam int FRAC_W  = NORM_W - 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int HALF_W  = MAG_W / 2;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ACC_W   = SUM_W + 2 * FRAC_W + 8;
  localparam int QUO_W   = FRAC_W + 1;
  localparam int NIT     = FRAC_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
  } norm_out_t;

endpackage

### sv/triangle_unit_normal_unit.sv
// One triangle per cycle while the output is not stalled; the sixteen per-bit compare stages of
// the square-root/divide recurrence set the depth.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled output holds; bubbles inside the pipe are filled while it waits.
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit
// Facet normal of one triangle, scaled to unit length in signed Q1.15.
// ----------------------------------------------------------------------------
module triangle_unit_normal_unit
  import tun_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tri_in_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output norm_out_t out_data
);

  localparam int NSTG = 6 + NIT + 1;
  localparam int OUTS = NSTG - 1;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] ld;

  logic signed [DIFF_W-1:0] u_r [3];
  logic signed [DIFF_W-1:0] v_r [3];
  logic signed [PROD_W-1:0] p_r [3];
  logic signed [PROD_W-1:0] q_r [3];
  logic [MAG_W-1:0]         mag_r [3];
  logic [2:0]               neg2_r, neg3_r, neg4_r, neg5_r;
  logic                     dgn2_r, dgn3_r, dgn4_r, dgn5_r;
  logic [2*HALF_W-1:0]      hh_r [3];
  logic [2*HALF_W-1:0]      hl_r [3];
  logic [2*HALF_W-1:0]      ll_r [3];
  logic [SQ_W-1:0]          sq_r [3];
  logic [SQ_W-1:0]          m2_r [3];
  logic [SUM_W-1:0]         sum_r;

  logic signed [ACC_W-1:0]  it_rem_r [NIT][3];
  logic signed [ACC_W-1:0]  it_y_r   [NIT][3];
  logic [QUO_W-1:0]         it_q_r   [NIT][3];
  logic [SUM_W-1:0]         it_s_r   [NIT];
  logic [2:0]               it_neg_r [NIT];
  logic                     it_dgn_r [NIT];

  logic signed [ACC_W-1:0]  it_rem_nxt [NIT][3];
  logic signed [ACC_W-1:0]  it_y_nxt   [NIT][3];
  logic [QUO_W-1:0]         it_q_nxt   [NIT][3];

  norm_out_t out_r;

  // a stage may load when empty or when the stage after it loads
  always_comb begin
    ld[OUTS] = !vld_r[OUTS] || !out_stall;
    for (int k = OUTS - 1; k >= 0; k--) begin
      ld[k] = !vld_r[k] || ld[k+1];
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld_r[OUTS];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // edge vectors
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      u_r[0] <= DIFF_W'(in_data.b_x) - DIFF_W'(in_data.a_x);
      u_r[1] <= DIFF_W'(in_data.b_y) - DIFF_W'(in_data.a_y);
      u_r[2] <= DIFF_W'(in_data.b_z) - DIFF_W'(in_data.a_z);
      v_r[0] <= DIFF_W'(in_data.c_x) - DIFF_W'(in_data.a_x);
      v_r[1] <= DIFF_W'(in_data.c_y) - DIFF_W'(in_data.a_y);
      v_r[2] <= DIFF_W'(in_data.c_z) - DIFF_W'(in_data.a_z);
    end
  end

  // cross product terms
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i] <= u_r[(i+1)%3] * v_r[(i+2)%3];
        q_r[i] <= u_r[(i+2)%3] * v_r[(i+1)%3];
      end
    end
  end

  // cross product, sign, magnitude and degenerate flag
  always_ff @(posedge clk) begin
    logic signed [CROSS_W-1:0] n [3];
    if (ld[2]) begin
      for (int i = 0; i < 3; i++) begin
        n[i]      = CROSS_W'(p_r[i]) - CROSS_W'(q_r[i]);
        neg2_r[i] <= n[i][CROSS_W-1];
        mag_r[i]  <= n[i][CROSS_W-1] ? MAG_W'(-n[i]) : MAG_W'(n[i]);
      end
      dgn2_r <= (p_r[0] == q_r[0]) && (p_r[1] == q_r[1]) && (p_r[2] == q_r[2]);
    end
  end

  // partial products of each square
  always_ff @(posedge clk) begin
    if (ld[3]) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= mag_r[i][MAG_W-1:HALF_W] * mag_r[i][MAG_W-1:HALF_W];
        hl_r[i] <= mag_r[i][MAG_W-1:HALF_W] * mag_r[i][HALF_W-1:0];
        ll_r[i] <= mag_r[i][HALF_W-1:0] * mag_r[i][HALF_W-1:0];
      end
      neg3_r <= neg2_r;
      dgn3_r <= dgn2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (SQ_W'(hh_r[i]) << (2 * HALF_W)) + (SQ_W'(hl_r[i]) << (HALF_W + 1))
                   + SQ_W'(ll_r[i]);
      end
      neg4_r <= neg3_r;
      dgn4_r <= dgn3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      m2_r   <= sq_r;
      neg5_r <= neg4_r;
      dgn5_r <= dgn4_r;
    end
  end

  // one quotient bit per stage: keep rem = m2*2^(2F+2) - (2q-1)^2*s
  // and y = (2q-1)*s, so each trial needs only shifts and adds
  always_comb begin
    logic signed [ACC_W-1:0] rem;
    logic signed [ACC_W-1:0] yv;
    logic [QUO_W-1:0]        qv;
    logic signed [ACC_W-1:0] ss;
    logic signed [ACC_W-1:0] dl;
    for (int j = 0; j < NIT; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (j == 0) begin
          ss  = $signed(ACC_W'(sum_r));
          rem = $signed(ACC_W'(m2_r[i]) << (2 * FRAC_W + 2)) - ss;
          yv  = -ss;
          qv  = '0;
        end else begin
          ss  = $signed(ACC_W'(it_s_r[j-1]));
          rem = it_rem_r[j-1][i];
          yv  = it_y_r[j-1][i];
          qv  = it_q_r[j-1][i];
        end
        dl = (yv <<< (FRAC_W - j + 2)) + (ss <<< (2 * (FRAC_W - j) + 2));
        if (!qv[FRAC_W] && (dl <= rem)) begin
          it_rem_nxt[j][i] = rem - dl;
          it_y_nxt[j][i]   = yv + (ss <<< (FRAC_W - j + 1));
          it_q_nxt[j][i]   = qv | (QUO_W'(1) << (FRAC_W - j));
        end else begin
          it_rem_nxt[j][i] = rem;
          it_y_nxt[j][i]   = yv;
          it_q_nxt[j][i]   = qv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      it_s_r[0]   <= sum_r;
      it_neg_r[0] <= neg5_r;
      it_dgn_r[0] <= dgn5_r;
    end
    for (int j = 1; j < NIT; j++) begin
      if (ld[6+j]) begin
        it_s_r[j]   <= it_s_r[j-1];
        it_neg_r[j] <= it_neg_r[j-1];
        it_dgn_r[j] <= it_dgn_r[j-1];
      end
    end
    for (int j = 0; j < NIT; j++) begin
      if (ld[6+j]) begin
        it_rem_r[j] <= it_rem_nxt[j];
        it_y_r[j]   <= it_y_nxt[j];
        it_q_r[j]   <= it_q_nxt[j];
      end
    end
  end

  // saturate a magnitude of one, restore sign, zero a degenerate triangle
  always_ff @(posedge clk) begin
    logic [NORM_W-1:0] mg [3];
    logic [NORM_W-1:0] cv [3];
    if (ld[OUTS]) begin
      for (int i = 0; i < 3; i++) begin
        mg[i] = it_q_r[NIT-1][i][FRAC_W] ? {1'b0, {FRAC_W{1'b1}}}
                                         : {1'b0, it_q_r[NIT-1][i][FRAC_W-1:0]};
        cv[i] = it_dgn_r[NIT-1] ? '0 : (it_neg_r[NIT-1][i] ? -mg[i] : mg[i]);
      end
      out_r.normal_x   <= $signed(cv[0]);
      out_r.normal_y   <= $signed(cv[1]);
      out_r.normal_z   <= $signed(cv[2]);
      out_r.degenerate <= it_dgn_r[NIT-1];
    end
  end

endmodule

### sv/tun_chk.sv
// ----------------------------------------------------------------------------
// tun_chk
// Port-level checks for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
module tun_chk
  import tun_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input tri_in_t   in_data,
  input logic      out_valid,
  input logic      out_stall,
  input norm_out_t out_data
);

  localparam logic signed [NORM_W-1:0] MinNorm = {1'b1, {FRAC_W{1'b0}}};

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate beat with nonzero normal");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.normal_x != MinNorm && out_data.normal_y != MinNorm &&
                  out_data.normal_z != MinNorm)
    else $error("normal component not saturated");

endmodule

bind triangle_unit_normal_unit tun_chk u_tun_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
